>>> hw/rtl/great_circle_distance_bearing_unit_macros.svh
// assertion macros shared by the checker of the distance and bearing unit
// needs clk_i and rst_ni in the scope of each use
`ifndef GREAT_CIRCLE_DISTANCE_BEARING_UNIT_MACROS_SVH
`define GREAT_CIRCLE_DISTANCE_BEARING_UNIT_MACROS_SVH

// property that must hold in the same cycle as its trigger
`define GCDB_ASSERT_SAME(label, trig, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |-> (prop)) \
    else $error("gcdb check failed");

// property that must hold in the cycle after its trigger
`define GCDB_ASSERT_NEXT(label, trig, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (prop)) \
    else $error("gcdb check failed");

`endif

>>> hw/rtl/gcdb_pkg.sv
// types, constants and tables of the distance and bearing unit
// no dependencies
package gcdb_pkg;

  localparam int CORDIC_STEPS = 24;
  localparam int STEP_W = $clog2(CORDIC_STEPS + 1);
  localparam int IDX_W = $clog2(CORDIC_STEPS);
  localparam int DP_W = 36;
  localparam int MUL_W = 33;
  localparam int PROD_W = 2 * MUL_W;
  localparam int RADIUS_W = 23;
  localparam int DIST_W = 25;
  localparam int ROOT_W = 32;
  localparam int RAD_W = 64;
  localparam int SQ_STEPS = 32;
  localparam int SQ_CNT_W = 5;
  localparam int ADDR_W = 3;

  localparam logic signed [DP_W-1:0] GAIN_Q30 = 36'sd652032874;
  localparam logic signed [DP_W-1:0] PI_Q30 = 36'sd3373259426;
  localparam logic signed [DP_W-1:0] TWO_PI_Q30 = 36'sd6746518852;
  localparam logic signed [DP_W-1:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [DP_W-1:0] Q30_ONE = 36'sd1073741824;
  localparam logic [31:0] TWO_PI_Q29 = 32'd3373259426;
  localparam logic [DIST_W-1:0] DIST_MAX = 25'd20106193;
  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 23'd6371000;
  localparam logic REG_RADIUS = 1'b0;

  typedef enum logic {
    REQ_FIX   = 1'b0,
    REQ_QUERY = 1'b1
  } req_e;

  typedef enum logic [4:0] {
    OP_SC_DLAT,
    OP_SC_DLON,
    OP_SC_LAT,
    OP_SC_FLAT,
    OP_SC_DLON2,
    OP_MUL_S1S1,
    OP_MUL_CC,
    OP_MUL_S2S2,
    OP_MUL_A,
    OP_SQRT_A,
    OP_SQRT_B,
    OP_ATAN_C,
    OP_MUL_DIST,
    OP_MUL_BY,
    OP_MUL_CS,
    OP_MUL_SC,
    OP_MUL_BX,
    OP_ATAN_B,
    OP_NORM_B,
    OP_ROUND_B
  } op_e;

  localparam op_e OP_FIRST = OP_SC_DLAT;
  localparam op_e OP_LAST = OP_ROUND_B;

  typedef enum logic [1:0] {
    U_CORDIC,
    U_SQRT,
    U_MUL,
    U_ALU
  } unit_e;

  typedef enum logic [1:0] {
    CT_IDLE,
    CT_ISSUE,
    CT_WAIT,
    CT_HOLD
  } ctrl_st_e;

  typedef enum logic [2:0] {
    CR_IDLE,
    CR_WRAP,
    CR_FOLD,
    CR_QUAD,
    CR_ITER,
    CR_POST,
    CR_DONE
  } cordic_st_e;

  typedef enum logic [1:0] {
    SQ_IDLE,
    SQ_RUN,
    SQ_DONE
  } sqrt_st_e;

  typedef struct packed {
    logic               req_type;
    logic signed [31:0] point_latitude;
    logic signed [31:0] point_longitude;
    logic [31:0]        fix_vertical_accuracy_mm;
  } in_word_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance_m;
    logic [31:0]       bearing;
    logic [31:0]       accuracy_mm;
  } out_word_t;

  typedef struct packed {
    logic load_fix;
    logic load_query;
    logic start;
    op_e  op;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
  } dp_status_t;

  function automatic logic [29:0] atan_entry(input logic [4:0] idx);
    logic [29:0] v;
    unique case (idx)
      5'd0:  v = 30'd843314857;
      5'd1:  v = 30'd497837829;
      5'd2:  v = 30'd263043837;
      5'd3:  v = 30'd133525159;
      5'd4:  v = 30'd67021687;
      5'd5:  v = 30'd33543516;
      5'd6:  v = 30'd16775851;
      5'd7:  v = 30'd8388437;
      5'd8:  v = 30'd4194283;
      5'd9:  v = 30'd2097149;
      5'd10: v = 30'd1048576;
      5'd11: v = 30'd524288;
      5'd12: v = 30'd262144;
      5'd13: v = 30'd131072;
      5'd14: v = 30'd65536;
      5'd15: v = 30'd32768;
      5'd16: v = 30'd16384;
      5'd17: v = 30'd8192;
      5'd18: v = 30'd4096;
      5'd19: v = 30'd2048;
      5'd20: v = 30'd1024;
      5'd21: v = 30'd512;
      5'd22: v = 30'd256;
      5'd23: v = 30'd128;
      5'd24: v = 30'd64;
      5'd25: v = 30'd32;
      5'd26: v = 30'd16;
      5'd27: v = 30'd8;
      5'd28: v = 30'd4;
      5'd29: v = 30'd2;
      5'd30: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

>>> hw/rtl/gcdb_cordic.sv
// shared cordic rotator: sine and cosine by rotation, atan2 by vectoring
// depends on gcdb_pkg
module gcdb_cordic import gcdb_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic                   vec_i,
  input  logic signed [DP_W-1:0] ang_i,
  input  logic signed [DP_W-1:0] x_i,
  input  logic signed [DP_W-1:0] y_i,
  output logic signed [DP_W-1:0] x_o,
  output logic signed [DP_W-1:0] y_o,
  output logic signed [DP_W-1:0] z_o,
  output logic                   done_o
);

  cordic_st_e state_q, state_d;
  logic [STEP_W-1:0] step_q;
  logic signed [DP_W-1:0] x_q, y_q, z_q;
  logic signed [DP_W-1:0] dx, dy, atan_v;
  logic neg_q, vec_q, up;

  always_comb begin
    dx = y_q >>> step_q[IDX_W-1:0];
    dy = x_q >>> step_q[IDX_W-1:0];
    atan_v = DP_W'(atan_entry(5'(step_q[IDX_W-1:0])));
    up = vec_q ? y_q[DP_W-1] : ~z_q[DP_W-1];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      CR_IDLE: if (start_i) state_d = vec_i ? CR_ITER : CR_WRAP;
      CR_WRAP: state_d = CR_FOLD;
      CR_FOLD: state_d = CR_QUAD;
      CR_QUAD: state_d = CR_ITER;
      CR_ITER: if (step_q == STEP_W'(CORDIC_STEPS - 1)) state_d = CR_POST;
      CR_POST: state_d = CR_DONE;
      CR_DONE: state_d = CR_IDLE;
      default: state_d = CR_IDLE;
    endcase
  end

  always_comb begin
    done_o = (state_q == CR_DONE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CR_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= (state_q == CR_ITER) ? step_q + STEP_W'(1) : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      CR_IDLE: begin
        if (start_i) begin
          vec_q <= vec_i;
          neg_q <= 1'b0;
          if (vec_i) begin
            if (x_i < 0) begin
              x_q <= -x_i;
              y_q <= -y_i;
              z_q <= (y_i >= 0) ? PI_Q30 : -PI_Q30;
            end else begin
              x_q <= x_i;
              y_q <= y_i;
              z_q <= '0;
            end
          end else begin
            x_q <= GAIN_Q30;
            y_q <= '0;
            z_q <= ang_i;
          end
        end
      end
      CR_WRAP: begin
        if (z_q >= TWO_PI_Q30) z_q <= z_q - TWO_PI_Q30;
        else if (z_q <= -TWO_PI_Q30) z_q <= z_q + TWO_PI_Q30;
      end
      CR_FOLD: begin
        if (z_q > PI_Q30) z_q <= z_q - TWO_PI_Q30;
        else if (z_q < -PI_Q30) z_q <= z_q + TWO_PI_Q30;
      end
      CR_QUAD: begin
        if (z_q > HALF_PI_Q30) begin
          z_q   <= z_q - PI_Q30;
          neg_q <= 1'b1;
        end else if (z_q < -HALF_PI_Q30) begin
          z_q   <= z_q + PI_Q30;
          neg_q <= 1'b1;
        end
      end
      CR_ITER: begin
        if (up) begin
          x_q <= x_q - dx;
          y_q <= y_q + dy;
          z_q <= z_q - atan_v;
        end else begin
          x_q <= x_q + dx;
          y_q <= y_q - dy;
          z_q <= z_q + atan_v;
        end
      end
      CR_POST: begin
        if (neg_q) begin
          x_q <= -x_q;
          y_q <= -y_q;
        end
      end
      default: ;
    endcase
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;

endmodule

>>> hw/rtl/gcdb_isqrt.sv
// bit-serial floor square root, one result bit per cycle
// depends on gcdb_pkg
module gcdb_isqrt import gcdb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [RAD_W-1:0]  val_i,
  output logic [ROOT_W-1:0] root_o,
  output logic              done_o
);

  sqrt_st_e state_q, state_d;
  logic [SQ_CNT_W-1:0] cnt_q;
  logic [RAD_W-1:0] v_q, res_q, bit_q, trial;

  assign trial = res_q + bit_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SQ_IDLE: if (start_i) state_d = SQ_RUN;
      SQ_RUN:  if (cnt_q == SQ_CNT_W'(SQ_STEPS - 1)) state_d = SQ_DONE;
      SQ_DONE: state_d = SQ_IDLE;
      default: state_d = SQ_IDLE;
    endcase
  end

  always_comb begin
    done_o = (state_q == SQ_DONE);
    root_o = res_q[ROOT_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SQ_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= (state_q == SQ_RUN) ? cnt_q + SQ_CNT_W'(1) : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == SQ_IDLE && start_i) begin
      v_q   <= val_i;
      res_q <= '0;
      bit_q <= RAD_W'(1) << (RAD_W - 2);
    end else if (state_q == SQ_RUN) begin
      if (v_q >= trial) begin
        v_q   <= v_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

endmodule

>>> hw/rtl/gcdb_datapath.sv
// datapath: stored fix, work registers, multiplier, cordic and square root
// depends on gcdb_pkg, gcdb_cordic and gcdb_isqrt
module gcdb_datapath import gcdb_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dp_cmd_t             cmd_i,
  input  in_word_t            in_word_i,
  input  logic [RADIUS_W-1:0] radius_i,
  output dp_status_t          status_o,
  output out_word_t           out_word_o
);

  logic signed [31:0] fix_lat_q, fix_lon_q, tgt_lat_q, tgt_lon_q;
  logic [31:0] fix_acc_q;
  op_e op_q;
  unit_e unit;
  logic launch_q, mul_wb_q, wb;

  logic signed [DP_W-1:0] s1_q, s2_q, slat_q, clat_q, sf_q, cf_q, sd_q, cd_q;
  logic signed [DP_W-1:0] t0_q, t1_q, t2_q, by_q, bx_q, br_q, ang_q;
  logic [30:0] a_q;
  logic [ROOT_W-1:0] sa_q, sb_q;
  logic [DIST_W-1:0] dist_q;
  logic [31:0] bearing_q;
  logic signed [PROD_W-1:0] prod_q;
  out_word_t out_q;

  logic signed [DP_W-1:0] dlat, dlon, cr_ang, cr_x, cr_y, cr_xo, cr_yo, cr_zo;
  logic cr_vec, cr_start, cr_done;
  logic [RAD_W-1:0] sq_val;
  logic [ROOT_W-1:0] sq_root;
  logic sq_start, sq_done;
  logic signed [MUL_W-1:0] mul_a, mul_b;
  logic signed [DP_W-1:0] mq, a_sum, br_adj, br_norm, b_half;
  logic [30:0] a_clamp;
  logic [PROD_W-1:0] d_round, d_shift;
  logic [DIST_W-1:0] dist_d;
  logic [31:0] bearing_d;

  always_comb begin
    case (op_q) inside
      OP_SC_DLAT, OP_SC_DLON, OP_SC_LAT, OP_SC_FLAT, OP_SC_DLON2, OP_ATAN_C, OP_ATAN_B:
        unit = U_CORDIC;
      OP_SQRT_A, OP_SQRT_B: unit = U_SQRT;
      OP_NORM_B, OP_ROUND_B: unit = U_ALU;
      default: unit = U_MUL;
    endcase
  end

  always_comb begin
    dlat = DP_W'(fix_lat_q) - DP_W'(tgt_lat_q);
    dlon = DP_W'(fix_lon_q) - DP_W'(tgt_lon_q);
    cr_ang = '0;
    cr_x = '0;
    cr_y = '0;
    cr_vec = 1'b0;
    sq_val = '0;
    mul_a = '0;
    mul_b = '0;
    case (op_q)
      OP_SC_DLAT:  cr_ang = dlat;
      OP_SC_DLON:  cr_ang = dlon;
      OP_SC_LAT:   cr_ang = DP_W'(tgt_lat_q) <<< 1;
      OP_SC_FLAT:  cr_ang = DP_W'(fix_lat_q) <<< 1;
      OP_SC_DLON2: cr_ang = dlon <<< 1;
      OP_ATAN_C: begin
        cr_vec = 1'b1;
        cr_y = DP_W'(sa_q);
        cr_x = DP_W'(sb_q);
      end
      OP_ATAN_B: begin
        cr_vec = 1'b1;
        cr_y = by_q;
        cr_x = bx_q;
      end
      OP_SQRT_A: sq_val = RAD_W'(a_q) << 30;
      OP_SQRT_B: sq_val = RAD_W'(Q30_ONE[30:0] - a_q) << 30;
      OP_MUL_S1S1: begin
        mul_a = MUL_W'(s1_q);
        mul_b = MUL_W'(s1_q);
      end
      OP_MUL_CC: begin
        mul_a = MUL_W'(clat_q);
        mul_b = MUL_W'(cf_q);
      end
      OP_MUL_S2S2: begin
        mul_a = MUL_W'(s2_q);
        mul_b = MUL_W'(s2_q);
      end
      OP_MUL_A: begin
        mul_a = MUL_W'(t1_q);
        mul_b = MUL_W'(t2_q);
      end
      OP_MUL_DIST: begin
        mul_a = MUL_W'(radius_i);
        mul_b = MUL_W'(ang_q <<< 1);
      end
      OP_MUL_BY: begin
        mul_a = MUL_W'(sd_q);
        mul_b = MUL_W'(cf_q);
      end
      OP_MUL_CS: begin
        mul_a = MUL_W'(clat_q);
        mul_b = MUL_W'(sf_q);
      end
      OP_MUL_SC: begin
        mul_a = MUL_W'(slat_q);
        mul_b = MUL_W'(cf_q);
      end
      OP_MUL_BX: begin
        mul_a = MUL_W'(t1_q);
        mul_b = MUL_W'(cd_q);
      end
      default: ;
    endcase
    cr_start = launch_q && unit == U_CORDIC;
    sq_start = launch_q && unit == U_SQRT;
  end

  gcdb_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cr_start),
    .vec_i   (cr_vec),
    .ang_i   (cr_ang),
    .x_i     (cr_x),
    .y_i     (cr_y),
    .x_o     (cr_xo),
    .y_o     (cr_yo),
    .z_o     (cr_zo),
    .done_o  (cr_done)
  );

  gcdb_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .val_i   (sq_val),
    .root_o  (sq_root),
    .done_o  (sq_done)
  );

  // post-processing of each step
  always_comb begin
    mq = DP_W'(prod_q >>> 30);
    a_sum = t0_q + mq;
    if (a_sum < 0) a_clamp = '0;
    else if (a_sum > Q30_ONE) a_clamp = Q30_ONE[30:0];
    else a_clamp = a_sum[30:0];
    d_round = $unsigned(prod_q) + (PROD_W'(1) << 29);
    d_shift = d_round >> 30;
    dist_d = (d_shift > PROD_W'(DIST_MAX)) ? DIST_MAX : d_shift[DIST_W-1:0];
    if (br_q < 0) br_adj = br_q + TWO_PI_Q30;
    else if (br_q >= TWO_PI_Q30) br_adj = br_q - TWO_PI_Q30;
    else br_adj = br_q;
    br_norm = (br_adj < 0) ? '0 : br_adj;
    b_half = (br_q + DP_W'(1)) >>> 1;
    bearing_d = (b_half >= DP_W'(TWO_PI_Q29)) ? 32'(b_half - DP_W'(TWO_PI_Q29))
                                               : b_half[31:0];
    wb = cr_done || sq_done || mul_wb_q || (launch_q && unit == U_ALU);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fix_lat_q <= '0;
      fix_lon_q <= '0;
      fix_acc_q <= '1;
      op_q      <= OP_FIRST;
      launch_q  <= 1'b0;
      mul_wb_q  <= 1'b0;
    end else begin
      if (cmd_i.load_fix) begin
        fix_lat_q <= in_word_i.point_latitude;
        fix_lon_q <= in_word_i.point_longitude;
        fix_acc_q <= in_word_i.fix_vertical_accuracy_mm;
      end
      if (cmd_i.start) op_q <= cmd_i.op;
      launch_q <= cmd_i.start;
      mul_wb_q <= launch_q && unit == U_MUL;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (cmd_i.load_query) begin
      tgt_lat_q <= in_word_i.point_latitude;
      tgt_lon_q <= in_word_i.point_longitude;
    end
    if (cmd_i.load_out) begin
      out_q.distance_m  <= dist_q;
      out_q.bearing     <= bearing_q;
      out_q.accuracy_mm <= fix_acc_q;
    end
    if (wb) begin
      case (op_q)
        OP_SC_DLAT: s1_q <= cr_yo;
        OP_SC_DLON: s2_q <= cr_yo;
        OP_SC_LAT: begin
          slat_q <= cr_yo;
          clat_q <= cr_xo;
        end
        OP_SC_FLAT: begin
          sf_q <= cr_yo;
          cf_q <= cr_xo;
        end
        OP_SC_DLON2: begin
          sd_q <= cr_yo;
          cd_q <= cr_xo;
        end
        OP_MUL_S1S1: t0_q <= mq;
        OP_MUL_CC:   t1_q <= mq;
        OP_MUL_S2S2: t2_q <= mq;
        OP_MUL_A:    a_q <= a_clamp;
        OP_SQRT_A:   sa_q <= sq_root;
        OP_SQRT_B:   sb_q <= sq_root;
        OP_ATAN_C:   ang_q <= (cr_zo < 0) ? '0 : cr_zo;
        OP_MUL_DIST: dist_q <= dist_d;
        OP_MUL_BY:   by_q <= mq;
        OP_MUL_CS:   t0_q <= mq;
        OP_MUL_SC:   t1_q <= mq;
        OP_MUL_BX:   bx_q <= t0_q - mq;
        OP_ATAN_B:   br_q <= cr_zo;
        OP_NORM_B:   br_q <= br_norm;
        OP_ROUND_B:  bearing_q <= bearing_d;
        default: ;
      endcase
    end
  end

  assign status_o.done = wb;
  assign out_word_o = out_q;

endmodule

>>> hw/rtl/gcdb_ctrl.sv
// controller: input handshake, step sequencer over the datapath, result word
// depends on gcdb_pkg
module gcdb_ctrl import gcdb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       req_type_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  ctrl_st_e state_q, state_d;
  op_e pc_q;
  logic out_valid_q, accept, out_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      CT_IDLE:  if (accept && req_type_i == REQ_QUERY) state_d = CT_ISSUE;
      CT_ISSUE: state_d = CT_WAIT;
      CT_WAIT: begin
        if (status_i.done) state_d = (pc_q == OP_LAST) ? CT_HOLD : CT_ISSUE;
      end
      CT_HOLD:  if (out_free) state_d = CT_IDLE;
      default:  state_d = CT_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = (state_q == CT_IDLE);
    accept = in_valid_i && in_ready_o;
    out_free = !out_valid_q || out_ready_i;
    cmd_o.load_fix = accept && req_type_i == REQ_FIX;
    cmd_o.load_query = accept && req_type_i == REQ_QUERY;
    cmd_o.start = (state_q == CT_ISSUE);
    cmd_o.op = pc_q;
    cmd_o.load_out = (state_q == CT_HOLD) && out_free;
    out_valid_o = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CT_IDLE;
      pc_q        <= OP_FIRST;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == CT_IDLE) pc_q <= OP_FIRST;
      else if (state_q == CT_WAIT && status_i.done && pc_q != OP_LAST) pc_q <= op_e'(pc_q + 1'b1);
      if (cmd_o.load_out) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

endmodule

>>> hw/rtl/great_circle_distance_bearing_unit.sv
// great-circle distance and initial bearing unit, top level with register port
// depends on gcdb_pkg, gcdb_ctrl and gcdb_datapath
// A fix word (req_type 0) stores latitude, longitude and accuracy on acceptance and
// gives no result. A query word (req_type 1) gives one result word: haversine
// distance in metres (saturated), bearing from the target toward the fix in unsigned
// Q3.29 radians, and the stored accuracy. A query runs five sine/cosine passes and
// two atan2 passes one after another through a single shared cordic rotator, two
// square roots in a bit-serial unit, nine products through one 33 by 33 multiplier
// and two bearing fix-up steps, and then loads the result word. One query is worked
// on at a time; the input is ready again in the cycle the result word appears, and a
// new word is taken while the previous result still waits at the output. The earth
// radius sits at address 0.
module great_circle_distance_bearing_unit import gcdb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_word_t          in_word_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_word_t         out_word_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [RADIUS_W-1:0] radius_q;
  logic radius_sel;
  dp_cmd_t cmd;
  dp_status_t status;

  assign radius_sel = (paddr[ADDR_W-1:2] == REG_RADIUS);
  assign pready = 1'b1;
  assign prdata = radius_sel ? 32'(radius_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RADIUS_RESET;
    end else if (psel && penable && pwrite && pready && radius_sel) begin
      radius_q <= pwdata[RADIUS_W-1:0];
    end
  end

  gcdb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (in_word_i.req_type),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  gcdb_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_word_i  (in_word_i),
    .radius_i   (radius_q),
    .status_o   (status),
    .out_word_o (out_word_o)
  );

endmodule

>>> hw/rtl/gcdb_checker.sv
// port-level checks of the distance and bearing unit, bound to the top level
// depends on gcdb_pkg and the assertion macro header
`include "great_circle_distance_bearing_unit_macros.svh"

module gcdb_checker import gcdb_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_i,
  input logic      out_ready_i,
  input out_word_t out_word_i
);

  `GCDB_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i)
  `GCDB_ASSERT_NEXT(a_out_stable, out_valid_i && !out_ready_i, $stable(out_word_i))
  `GCDB_ASSERT_SAME(a_dist_sat, out_valid_i, out_word_i.distance_m <= DIST_MAX)
  `GCDB_ASSERT_SAME(a_bearing_range, out_valid_i, out_word_i.bearing < TWO_PI_Q29)

endmodule

bind great_circle_distance_bearing_unit gcdb_checker u_gcdb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_word_i  (out_word_o)
);
